@@ sv/spectral_voice_detector_defines.svh @@
// assertion macros for the spectral voice detector
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SPECTRAL_VOICE_DETECTOR_DEFINES_SVH
`define SPECTRAL_VOICE_DETECTOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spectral voice detector check failed");

// next-cycle implication, off during reset
`define SVD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spectral voice detector check failed");

`endif

@@ sv/svd_pkg.sv @@
// shared widths, register indexes, reset values and types of the spectral voice detector
// no dependencies
package svd_pkg;

    localparam int MAX_BINS = 1024;
    localparam int MAG_W    = 16;
    localparam int SUM_W    = 26;
    localparam int CNT_W    = $clog2(MAX_BINS + 1);
    localparam int IDX_W    = 10;
    localparam int MODE_W   = 4;
    localparam int REG_W    = 16;
    localparam int HZ_W     = 16;
    localparam int FRAC_W   = 8;

    localparam int AMP_PROD_W   = REG_W + CNT_W;
    localparam int PITCH_PROD_W = IDX_W + REG_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUDGE_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_RESOLUTION  = 2'd3;

    // judge_mode bit positions
    localparam int MODE_MEAN_ABOVE  = 0;
    localparam int MODE_PITCH_ABOVE = 1;
    localparam int MODE_MEAN_BELOW  = 2;
    localparam int MODE_PITCH_BELOW = 3;

    localparam logic [MODE_W-1:0] RST_JUDGE_MODE      = 4'd3;
    localparam logic [REG_W-1:0]  RST_AMP_THRESHOLD   = 16'd328;
    localparam logic [REG_W-1:0]  RST_PITCH_THRESHOLD = 16'd1000;
    localparam logic [REG_W-1:0]  RST_BIN_RESOLUTION  = 16'd689;

    typedef struct packed {
        logic [MODE_W-1:0] judge_mode;
        logic [REG_W-1:0]  amp_threshold;
        logic [REG_W-1:0]  pitch_threshold;
        logic [REG_W-1:0]  bin_resolution;
    } t_cfg;

    // summary of one finished frame
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] level_sum;
        logic [CNT_W-1:0] bins_seen;
        logic [IDX_W-1:0] peak_index;
    } t_frame;

    typedef struct packed {
        logic             voice_detected;
        logic             mean_above;
        logic             pitch_above;
        logic [IDX_W-1:0] peak_bin;
        logic [HZ_W-1:0]  pitch_hz;
    } t_result;

endpackage

@@ sv/svd_bin_if.sv @@
// stream of spectrum bins into the detector
// depends on svd_pkg
interface svd_bin_if;
    import svd_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] bin_magnitude;
    logic             last_bin;

    modport source (output valid, output bin_magnitude, output last_bin, input ready);
    modport sink   (input valid, input bin_magnitude, input last_bin, output ready);
endinterface

@@ sv/svd_res_if.sv @@
// stream of per-frame results out of the detector
// depends on svd_pkg
interface svd_res_if;
    import svd_pkg::*;

    logic             valid;
    logic             ready;
    logic             voice_detected;
    logic             mean_above;
    logic             pitch_above;
    logic [IDX_W-1:0] peak_bin;
    logic [HZ_W-1:0]  pitch_hz;

    modport source (output valid, output voice_detected, output mean_above,
                    output pitch_above, output peak_bin, output pitch_hz, input ready);
    modport sink   (input valid, input voice_detected, input mean_above,
                    input pitch_above, input peak_bin, input pitch_hz, output ready);
endinterface

@@ sv/svd_accum.sv @@
// per-bin accumulation of sum, count and first strict peak; frame summary register
// depends on svd_pkg and svd_bin_if
module svd_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    svd_bin_if.sink         i_bin,
    input  logic            i_frm_ready,
    output svd_pkg::t_frame o_frm
);
    import svd_pkg::*;

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_bins_seen, n_bins_seen;
    logic [MAG_W-1:0] r_peak_level, n_peak_level;
    logic [IDX_W-1:0] r_peak_index, n_peak_index;
    t_frame           r_frm, n_frm;

    logic             w_accept;
    logic             w_in_range;
    logic [SUM_W-1:0] w_sum_upd;
    logic [CNT_W-1:0] w_cnt_upd;
    logic [MAG_W-1:0] w_lvl_upd;
    logic [IDX_W-1:0] w_idx_upd;

    assign i_bin.ready = !r_frm.valid || i_frm_ready;
    assign w_accept    = i_bin.valid && i_bin.ready;
    assign w_in_range  = r_bins_seen < CNT_W'(MAX_BINS);

    // bins past the frame limit leave the state alone
    always_comb begin
        w_sum_upd = r_sum;
        w_cnt_upd = r_bins_seen;
        w_lvl_upd = r_peak_level;
        w_idx_upd = r_peak_index;
        if (w_in_range) begin
            w_sum_upd = r_sum + SUM_W'(i_bin.bin_magnitude);
            w_cnt_upd = r_bins_seen + CNT_W'(1);
            if (i_bin.bin_magnitude > r_peak_level) begin
                w_lvl_upd = i_bin.bin_magnitude;
                w_idx_upd = r_bins_seen[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        n_sum        = r_sum;
        n_bins_seen  = r_bins_seen;
        n_peak_level = r_peak_level;
        n_peak_index = r_peak_index;
        n_frm        = r_frm;
        if (i_frm_ready) begin
            n_frm.valid = 1'b0;
        end
        if (w_accept) begin
            if (i_bin.last_bin) begin
                n_frm.valid      = 1'b1;
                n_frm.level_sum  = w_sum_upd;
                n_frm.bins_seen  = w_cnt_upd;
                n_frm.peak_index = w_idx_upd;
                n_sum            = '0;
                n_bins_seen      = '0;
                n_peak_level     = '0;
                n_peak_index     = '0;
            end else begin
                n_sum        = w_sum_upd;
                n_bins_seen  = w_cnt_upd;
                n_peak_level = w_lvl_upd;
                n_peak_index = w_idx_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_bins_seen  <= '0;
            r_peak_level <= '0;
            r_peak_index <= '0;
            r_frm.valid  <= 1'b0;
        end else begin
            r_sum        <= n_sum;
            r_bins_seen  <= n_bins_seen;
            r_peak_level <= n_peak_level;
            r_peak_index <= n_peak_index;
            r_frm.valid  <= n_frm.valid;
        end
        r_frm.level_sum  <= n_frm.level_sum;
        r_frm.bins_seen  <= n_frm.bins_seen;
        r_frm.peak_index <= n_frm.peak_index;
    end

    assign o_frm = r_frm;

endmodule

@@ sv/svd_judge.sv @@
// frame judgment: mean and pitch tests, pitch scaling, result register
// depends on svd_pkg and svd_res_if
module svd_judge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svd_pkg::t_frame i_frm,
    input  svd_pkg::t_cfg   i_cfg,
    output logic            o_frm_ready,
    svd_res_if.source       o_res
);
    import svd_pkg::*;

    t_result                 r_res, n_res;
    logic                    r_res_valid, n_res_valid;

    logic                    w_adv;
    logic [AMP_PROD_W-1:0]   w_amp_prod;
    logic [PITCH_PROD_W-1:0] w_pitch_prod;
    logic                    w_mean_up;
    logic                    w_pitch_up;
    logic                    w_ok;

    assign w_adv       = !r_res_valid || o_res.ready;
    assign o_frm_ready = w_adv;

    // mean > threshold done as sum > threshold * count, exact
    assign w_amp_prod   = AMP_PROD_W'(i_cfg.amp_threshold) * AMP_PROD_W'(i_frm.bins_seen);
    assign w_mean_up    = AMP_PROD_W'(i_frm.level_sum) > w_amp_prod;
    assign w_pitch_prod = PITCH_PROD_W'(i_frm.peak_index) * PITCH_PROD_W'(i_cfg.bin_resolution);
    assign w_pitch_up   = w_pitch_prod > {PITCH_PROD_W'(i_cfg.pitch_threshold) << FRAC_W};

    assign w_ok = !(i_cfg.judge_mode[MODE_MEAN_ABOVE]  && !w_mean_up)
               && !(i_cfg.judge_mode[MODE_PITCH_ABOVE] && !w_pitch_up)
               && !(i_cfg.judge_mode[MODE_MEAN_BELOW]  &&  w_mean_up)
               && !(i_cfg.judge_mode[MODE_PITCH_BELOW] &&  w_pitch_up);

    always_comb begin
        n_res       = r_res;
        n_res_valid = r_res_valid;
        if (w_adv) begin
            n_res_valid = i_frm.valid;
            if (i_frm.valid) begin
                n_res.voice_detected = w_ok;
                n_res.mean_above     = w_mean_up;
                n_res.pitch_above    = w_pitch_up;
                n_res.peak_bin       = i_frm.peak_index;
                // saturate once the hertz value outgrows its field
                if (|w_pitch_prod[PITCH_PROD_W-1:FRAC_W+HZ_W]) begin
                    n_res.pitch_hz = '1;
                end else begin
                    n_res.pitch_hz = w_pitch_prod[FRAC_W+HZ_W-1:FRAC_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign o_res.valid          = r_res_valid;
    assign o_res.voice_detected = r_res.voice_detected;
    assign o_res.mean_above     = r_res.mean_above;
    assign o_res.pitch_above    = r_res.pitch_above;
    assign o_res.peak_bin       = r_res.peak_bin;
    assign o_res.pitch_hz       = r_res.pitch_hz;

endmodule

@@ sv/spectral_voice_detector.sv @@
// Spectral voice detector top level: configuration registers, accumulator, judge stage.
// Depends on svd_pkg, svd_bin_if, svd_res_if, svd_accum, svd_judge and the defines header.
//
// Usage: spectrum bins enter on i_bin, one magnitude per transfer, with last_bin set on
// the final bin of a frame. A full frame streams in at one bin per clock while
// i_bin.ready stays high. Only a last bin makes a result: one transfer on o_res carrying
// the detect flag, both above-threshold flags, the peak bin and the pitch in hertz.
// The result passes through the frame summary register, then the multiply-and-compare
// stage that loads the result register. Results can leave at one per cycle while
// o_res.ready stays high. Configuration is written through i_cfg_we / i_cfg_index /
// i_cfg_wdata; the user must write it only while the block is idle, which the block
// itself does not enforce; a write lands on the same edge.
// Reset (synchronous, i_rst_n low) restores the register defaults, clears the running
// frame and drops any pending result.
// When the receiver stalls, the result register holds and one further frame summary is
// buffered; bins keep flowing until a second frame ends, then i_bin.ready drops until
// the result is taken.
`include "spectral_voice_detector_defines.svh"

module spectral_voice_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    svd_bin_if.sink                       i_bin,
    svd_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [svd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [svd_pkg::REG_W-1:0]     i_cfg_wdata
);
    import svd_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_frame w_frm;
    logic   w_frm_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_JUDGE_MODE:      n_cfg.judge_mode      = i_cfg_wdata[MODE_W-1:0];
                CFG_AMP_THRESHOLD:   n_cfg.amp_threshold   = i_cfg_wdata;
                CFG_PITCH_THRESHOLD: n_cfg.pitch_threshold = i_cfg_wdata;
                CFG_BIN_RESOLUTION:  n_cfg.bin_resolution  = i_cfg_wdata;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.judge_mode      <= RST_JUDGE_MODE;
            r_cfg.amp_threshold   <= RST_AMP_THRESHOLD;
            r_cfg.pitch_threshold <= RST_PITCH_THRESHOLD;
            r_cfg.bin_resolution  <= RST_BIN_RESOLUTION;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    svd_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bin       (i_bin),
        .i_frm_ready (w_frm_ready),
        .o_frm       (w_frm)
    );

    svd_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm       (w_frm),
        .i_cfg       (r_cfg),
        .o_frm_ready (w_frm_ready),
        .o_res       (o_res)
    );

    // a frame end always leaves a summary behind
    `SVD_ASSERT_NXT(a_last_makes_frame, i_bin.valid && i_bin.ready && i_bin.last_bin, w_frm.valid)
    // both stages full and stalled: no more bins
    `SVD_ASSERT_IMP(a_full_blocks_input, w_frm.valid && o_res.valid && !o_res.ready, !i_bin.ready)
    // a pitch above any threshold needs a nonzero peak index
    `SVD_ASSERT_IMP(a_pitch_needs_peak, o_res.valid && (o_res.pitch_above || o_res.pitch_hz != 0), o_res.peak_bin != 0)

endmodule

@@ tb/sv/spectral_voice_detector_test.sv @@
// self-checking testbench for spectral_voice_detector: drives bin frames, predicts each
// frame verdict in a local model and checks every result transfer against it
// depends on svd_pkg, svd_bin_if, svd_res_if and the detector rtl
module spectral_voice_detector_test;
    import svd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_BINS  = 24;
    localparam int SAT_BINS    = 260;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_bin_item;

    typedef enum {SHAPE_NOISE, SHAPE_QUIET, SHAPE_SPIKE, SHAPE_FLAT} t_shape;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;

    svd_bin_if bin_if();
    svd_res_if res_if();

    spectral_voice_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bin       (bin_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // register copy and running frame state of the local model
    t_cfg              regs;
    logic [SUM_W-1:0]  frame_sum;
    logic [CNT_W-1:0]  frame_bins;
    logic [MAG_W-1:0]  frame_peak_level;
    logic [IDX_W-1:0]  frame_peak_index;

    t_bin_item bins_to_send[$];
    t_result   verdicts_due[$];

    int  bins_issued;
    int  bins_taken;
    int  frames_checked;
    int  voiced_frames;
    int  settings_used;
    int  mismatches;
    int  cycle_count;
    bit  calm;

    // fold one accepted bin into the frame and queue a verdict on the last one
    task automatic take_bin(input logic [MAG_W-1:0] mag, input logic last);
        logic [AMP_PROD_W-1:0]          floor_sum;
        logic [PITCH_PROD_W-1:0]        pitch_prod;
        logic [PITCH_PROD_W-FRAC_W-1:0] hz_full;
        logic                           mean_up;
        logic                           pitch_up;
        t_result                        verdict;
        if (frame_bins < MAX_BINS) begin
            frame_sum = frame_sum + SUM_W'(mag);
            if (mag > frame_peak_level) begin
                frame_peak_level = mag;
                frame_peak_index = frame_bins[IDX_W-1:0];
            end
            frame_bins = frame_bins + 1'b1;
        end
        if (last) begin
            floor_sum  = AMP_PROD_W'(regs.amp_threshold) * AMP_PROD_W'(frame_bins);
            mean_up    = AMP_PROD_W'(frame_sum) > floor_sum;
            pitch_prod = PITCH_PROD_W'(frame_peak_index) * PITCH_PROD_W'(regs.bin_resolution);
            pitch_up   = pitch_prod > (PITCH_PROD_W'(regs.pitch_threshold) << FRAC_W);
            hz_full    = pitch_prod[PITCH_PROD_W-1:FRAC_W];
            verdict.voice_detected = !((regs.judge_mode[MODE_MEAN_ABOVE] && !mean_up) ||
                                       (regs.judge_mode[MODE_PITCH_ABOVE] && !pitch_up) ||
                                       (regs.judge_mode[MODE_MEAN_BELOW] && mean_up) ||
                                       (regs.judge_mode[MODE_PITCH_BELOW] && pitch_up));
            verdict.mean_above  = mean_up;
            verdict.pitch_above = pitch_up;
            verdict.peak_bin    = frame_peak_index;
            verdict.pitch_hz    = (hz_full > {HZ_W{1'b1}}) ? {HZ_W{1'b1}} : hz_full[HZ_W-1:0];
            verdicts_due.push_back(verdict);
            frame_sum        = '0;
            frame_bins       = '0;
            frame_peak_level = '0;
            frame_peak_index = '0;
        end
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // bin driver
    always @(posedge i_clk) begin
        t_bin_item item;
        int        send_gap;
        if (!i_rst_n) begin
            bin_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (bin_if.valid && bin_if.ready) begin
                take_bin(bin_if.bin_magnitude, bin_if.last_bin);
                bins_taken++;
            end
            if (!bin_if.valid || bin_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    bin_if.valid <= 1'b0;
                end else if (bins_to_send.size() > 0) begin
                    item = bins_to_send.pop_front();
                    bins_issued++;
                    bin_if.valid         <= 1'b1;
                    bin_if.bin_magnitude <= item.mag;
                    bin_if.last_bin      <= item.last;
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 18);
                    end
                end else begin
                    bin_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        int      hold;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with none expected, actual peak %0d hz %0d",
                             $time, res_if.peak_bin, res_if.pitch_hz);
                end else begin
                    want = verdicts_due.pop_front();
                    report_field("voice_detected", 32'(want.voice_detected),
                                 32'(res_if.voice_detected));
                    report_field("mean_above", 32'(want.mean_above), 32'(res_if.mean_above));
                    report_field("pitch_above", 32'(want.pitch_above),
                                 32'(res_if.pitch_above));
                    report_field("peak_bin", 32'(want.peak_bin), 32'(res_if.peak_bin));
                    report_field("pitch_hz", 32'(want.pitch_hz), 32'(res_if.pitch_hz));
                    frames_checked++;
                    if (want.voice_detected) voiced_frames++;
                end
            end
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, verdicts_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_bin(input logic [MAG_W-1:0] mag, input logic last);
        bins_to_send.push_back('{mag: mag, last: last});
    endtask

    task automatic queue_frame(input int len, input t_shape shape);
        logic [MAG_W-1:0] level;
        logic [MAG_W-1:0] flat;
        flat = $urandom_range(0, 1) ? '0 : MAG_W'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_NOISE: level = MAG_W'($urandom_range(0, 65535));
                SHAPE_QUIET: level = MAG_W'($urandom_range(0, 700));
                SHAPE_SPIKE: level = ($urandom_range(0, 5) == 0) ?
                                     MAG_W'($urandom_range(0, 65535)) : '0;
                default:     level = flat;
            endcase
            add_bin(level, i == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_JUDGE_MODE:      regs.judge_mode      = value[MODE_W-1:0];
            CFG_AMP_THRESHOLD:   regs.amp_threshold   = value;
            CFG_PITCH_THRESHOLD: regs.pitch_threshold = value;
            default:             regs.bin_resolution  = value;
        endcase
    endtask

    task automatic set_regs(input logic [MODE_W-1:0] mode, input logic [REG_W-1:0] amp,
                            input logic [REG_W-1:0] pitch, input logic [REG_W-1:0] res);
        write_reg(CFG_JUDGE_MODE, REG_W'(mode));
        write_reg(CFG_AMP_THRESHOLD, amp);
        write_reg(CFG_PITCH_THRESHOLD, pitch);
        write_reg(CFG_BIN_RESOLUTION, res);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [REG_W-1:0] pick_value(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return REG_W'($urandom_range(lo, hi));
            default: return REG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // wait until every queued bin is taken and every verdict seen
    task automatic drain();
        @(posedge i_clk);
        while (bins_to_send.size() != 0 || bins_taken != bins_issued ||
               verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  amp;
        logic [REG_W-1:0]  pitch;
        logic [REG_W-1:0]  res;
        int                phase_bins;
        int                len;

        cfg_we               = 1'b0;
        cfg_index            = CFG_JUDGE_MODE;
        cfg_wdata            = '0;
        bin_if.valid         = 1'b0;
        bin_if.bin_magnitude = '0;
        bin_if.last_bin      = 1'b0;
        res_if.ready         = 1'b0;
        regs = '{judge_mode: RST_JUDGE_MODE, amp_threshold: RST_AMP_THRESHOLD,
                 pitch_threshold: RST_PITCH_THRESHOLD, bin_resolution: RST_BIN_RESOLUTION};
        frame_sum        = '0;
        frame_bins       = '0;
        frame_peak_level = '0;
        frame_peak_index = '0;
        settings_used    = 1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames on the reset settings
        add_bin(16'd0, 1'b1);
        add_bin(16'hFFFF, 1'b1);
        // tie for the maximum, first one wins
        add_bin(16'd5, 1'b0);
        add_bin(16'd9, 1'b0);
        add_bin(16'd9, 1'b0);
        add_bin(16'd3, 1'b1);
        // no bin above zero
        add_bin(16'd0, 1'b0);
        add_bin(16'd0, 1'b0);
        add_bin(16'd0, 1'b1);
        // peak on the last bin
        add_bin(16'd1, 1'b0);
        add_bin(16'd2, 1'b0);
        add_bin(16'hFFFF, 1'b1);
        // mean exactly at the threshold, then one above it
        add_bin(RST_AMP_THRESHOLD, 1'b0);
        add_bin(RST_AMP_THRESHOLD, 1'b1);
        add_bin(RST_AMP_THRESHOLD + 16'd1, 1'b0);
        add_bin(RST_AMP_THRESHOLD, 1'b1);
        drain();

        // long frame with its peak on the last bin: pitch saturates
        set_regs(MODE_W'((1 << MODE_MEAN_ABOVE) | (1 << MODE_PITCH_BELOW)), '1, 16'd1000, '1);
        for (int i = 0; i < SAT_BINS; i++) begin
            if (i < SAT_BINS - 1) add_bin(MAG_W'($urandom_range(0, 1000)), 1'b0);
            else add_bin(16'hFFFF, 1'b1);
        end
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       mode = '0;
                1:       mode = '1;
                2:       mode = MODE_W'(1 << MODE_MEAN_BELOW);
                3:       mode = MODE_W'(1 << MODE_PITCH_BELOW);
                4:       mode = MODE_W'(1 << MODE_MEAN_ABOVE);
                5:       mode = MODE_W'(1 << MODE_PITCH_ABOVE);
                default: mode = MODE_W'($urandom_range(0, 15));
            endcase
            if (phase == 0) begin
                amp   = '0;
                pitch = '0;
                res   = '0;
            end else if (phase == 1) begin
                amp   = '1;
                pitch = '1;
                res   = '1;
            end else begin
                amp   = pick_value(1, 800);
                pitch = pick_value(1, 300);
                res   = pick_value(100, 3000);
            end
            set_regs(mode, amp, pitch, res);
            if (phase == PHASES - 1) calm = 1'b1;
            phase_bins = 0;
            while (phase_bins < PHASE_BINS) begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 200) :
                                                     $urandom_range(1, 24);
                queue_frame(len, t_shape'($urandom_range(0, 3)));
                phase_bins += len;
            end
            drain();
        end

        $display("checked %0d frame verdicts (%0d voiced) from %0d bins", frames_checked,
                 voiced_frames, bins_taken);
        $display("under %0d register settings, with stalls on both channels", settings_used);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
